// ===== sv/vector_magnitude_range_assert.svh =====
// Assertion macros for the vector magnitude range RTL.
`ifndef VECTOR_MAGNITUDE_RANGE_ASSERT_SVH
`define VECTOR_MAGNITUDE_RANGE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define VMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define VMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vmr_pkg.sv =====
// Shared widths, constants and the result job type of the vector magnitude range block.
`default_nettype none
package vmr_pkg;

    localparam int MAX_DIMENSION  = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 8;
    localparam int BOUND_BITS     = 27;
    localparam int CFG_BITS       = 5;

    localparam int DIM_BITS    = $clog2(MAX_DIMENSION + 1);
    localparam int COUNT_BITS  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int SQUARE_BITS = 2 * COMPONENT_BITS - 1;
    localparam int SUM_BITS    = SQUARE_BITS + COUNT_BITS + 1;
    localparam int TRACK_BITS  = SUM_BITS + 1;
    localparam int ROOT_BITS   = (SUM_BITS + 2 * FRACTION_BITS + 1) / 2;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int STEP_BITS   = $clog2(ROOT_BITS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

    // One finished stream, handed from the front to the back.
    typedef struct packed {
        logic signed [TRACK_BITS-1:0] lo_value;
        logic signed [TRACK_BITS-1:0] hi_value;
        logic                         any_seen;
        logic                         root;
        logic                         length_error;
    } vmr_job_t;

endpackage
`default_nettype wire

// ===== sv/vmr_front.sv =====
// Front part: accepts components, squares them, accumulates vectors and tracks extremes.
`default_nettype none
module vmr_front
    import vmr_pkg::*;
(
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [DIM_BITS-1:0]              dim,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [COMPONENT_BITS-1:0] s_component,
    input  wire logic                             s_last_component,
    output logic                                  q_push,
    output vmr_job_t                              q_job,
    input  wire logic                             q_full
);

    // Stage A: squared magnitude of the incoming beat
    logic                             a_valid_reg;
    logic [SQUARE_BITS-1:0]           a_square_reg;
    logic signed [COMPONENT_BITS-1:0] a_value_reg;
    logic                             a_last_reg;

    logic [COMPONENT_BITS-1:0]        mag;
    logic [2*COMPONENT_BITS-1:0]      square_full;

    // Stage B: per-stream state
    logic [SUM_BITS-1:0]              sum_reg;
    logic [COUNT_BITS-1:0]            count_reg;
    logic signed [TRACK_BITS-1:0]     min_reg;
    logic signed [TRACK_BITS-1:0]     max_reg;
    logic                             any_reg;

    logic                             b_fire;
    logic                             scalar;
    logic                             complete;
    logic [DIM_BITS-1:0]              count_inc;
    logic [SUM_BITS-1:0]              sum_add;
    logic [SUM_BITS-1:0]              sum_next;
    logic [COUNT_BITS-1:0]            count_next;
    logic                             track_en;
    logic signed [TRACK_BITS-1:0]     track_value;
    logic signed [TRACK_BITS-1:0]     min_next;
    logic signed [TRACK_BITS-1:0]     max_next;
    logic                             any_next;

    // A last beat needs a free queue slot to leave stage A
    assign b_fire  = a_valid_reg && (!a_last_reg || !q_full);
    assign s_ready = !a_valid_reg || b_fire;

    // Magnitude and square; the most negative value maps to its unsigned magnitude
    always_comb begin
        mag = s_component[COMPONENT_BITS-1]
            ? COMPONENT_BITS'(~s_component + 1'b1)
            : COMPONENT_BITS'(s_component);
        square_full = mag * mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                a_valid_reg  <= 1'b1;
                a_square_reg <= square_full[SQUARE_BITS-1:0];
                a_value_reg  <= s_component;
                a_last_reg   <= s_last_component;
            end else if (b_fire) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // Accumulate and decide what gets tracked
    always_comb begin
        scalar    = (dim == DIM_BITS'(1));
        sum_add   = sum_reg + SUM_BITS'(a_square_reg);
        count_inc = DIM_BITS'(count_reg) + DIM_BITS'(1);
        complete  = (count_inc >= dim);
        if (scalar) begin
            track_en    = 1'b1;
            track_value = TRACK_BITS'(a_value_reg);
            sum_next    = '0;
            count_next  = '0;
        end else if (complete) begin
            track_en    = 1'b1;
            track_value = signed'({1'b0, sum_add});
            sum_next    = '0;
            count_next  = '0;
        end else begin
            track_en    = 1'b0;
            track_value = signed'({1'b0, sum_add});
            sum_next    = sum_add;
            count_next  = count_reg + COUNT_BITS'(1);
        end
        min_next = (track_en && (!any_reg || track_value < min_reg)) ? track_value : min_reg;
        max_next = (track_en && (!any_reg || track_value > max_reg)) ? track_value : max_reg;
        any_next = any_reg || track_en;

        q_push             = b_fire && a_last_reg;
        q_job.lo_value     = min_next;
        q_job.hi_value     = max_next;
        q_job.any_seen     = any_next;
        q_job.root         = !scalar;
        q_job.length_error = (count_next != '0);
    end

    // Stream state; a last beat clears it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            any_reg   <= 1'b0;
        end else if (b_fire) begin
            if (a_last_reg) begin
                sum_reg   <= '0;
                count_reg <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
                any_reg   <= 1'b0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                any_reg   <= any_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/vmr_queue.sv =====
// Short register queue of finished streams between front and back.
`default_nettype none
module vmr_queue
    import vmr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  vmr_job_t  push_job,
    output logic      full,
    input  wire logic pop,
    output vmr_job_t  pop_job,
    output logic      empty
);

    vmr_job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QFILL_BITS-1:0] fill_reg;

    assign full    = (fill_reg == QFILL_BITS'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_BITS-1:0] wrap_inc(input logic [QPTR_BITS-1:0] p);
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_BITS'(1);
    endfunction

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + QFILL_BITS'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - QFILL_BITS'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/vmr_sqrt.sv =====
// Iterative integer square root, one root bit per cycle, truncated.
`default_nettype none
module vmr_sqrt
    import vmr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [RAD_BITS-1:0] radicand,
    output logic                     busy,
    output logic                     done,
    output logic [ROOT_BITS-1:0]     root
);

    logic [RAD_BITS-1:0]  rad_reg;
    logic [ROOT_BITS+1:0] rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [ROOT_BITS+1:0] rem_shift;
    logic [ROOT_BITS+1:0] trial;
    logic                 fits;

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

    // One digit: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_shift = {rem_reg[ROOT_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= STEP_BITS'(ROOT_BITS - 1);
            end else if (busy_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
                root_reg <= {root_reg[ROOT_BITS-2:0], fits};
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - STEP_BITS'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/vmr_back.sv =====
// Back part: turns queued streams into bounds, taking roots where needed.
`default_nettype none
module vmr_back
    import vmr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  vmr_job_t                       q_job,
    input  wire logic                      q_empty,
    output logic                           q_pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [BOUND_BITS-1:0]   m_lower_bound,
    output logic signed [BOUND_BITS-1:0]   m_upper_bound,
    output logic                           m_length_error
);
`include "vector_magnitude_range_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT_LO,
        ST_ROOT_HI,
        ST_OUT
    } state_t;

    state_t               state_reg;
    vmr_job_t             job_reg;
    logic [ROOT_BITS-1:0] lo_root_reg;
    logic [ROOT_BITS-1:0] hi_root_reg;
    logic                 m_valid_reg;
    logic [BOUND_BITS-1:0] m_lower_reg;
    logic [BOUND_BITS-1:0] m_upper_reg;
    logic                 m_error_reg;

    logic                 out_free;
    logic                 out_load;
    logic                 in_root;
    logic                 head_direct;
    logic                 sqrt_start;
    logic [RAD_BITS-1:0]  sqrt_radicand;
    logic                 sqrt_busy;
    logic                 sqrt_done;
    logic [ROOT_BITS-1:0] sqrt_root;

    // Value scaled by the fraction bits, kept to the bound width
    function automatic logic [BOUND_BITS-1:0] scaled(input logic signed [TRACK_BITS-1:0] v);
        return BOUND_BITS'(v) << FRACTION_BITS;
    endfunction

    // Radicand for a tracked sum; negative values give a zero root
    function automatic logic [RAD_BITS-1:0] radicand_of(input logic signed [TRACK_BITS-1:0] v);
        if (v[TRACK_BITS-1]) begin
            return '0;
        end
        return RAD_BITS'(v[SUM_BITS-1:0]) << (2 * FRACTION_BITS);
    endfunction

    vmr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_valid        = m_valid_reg;
    assign m_lower_bound  = signed'(m_lower_reg);
    assign m_upper_bound  = signed'(m_upper_reg);
    assign m_length_error = m_error_reg;

    // Queue pop and root unit kick-off
    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        head_direct   = !q_job.root || !q_job.any_seen;
        q_pop         = (state_reg == ST_IDLE) && !q_empty && (!head_direct || out_free);
        in_root       = (state_reg == ST_ROOT_LO) || (state_reg == ST_ROOT_HI);
        out_load      = ((state_reg == ST_IDLE) && !q_empty && head_direct && out_free)
                     || ((state_reg == ST_OUT) && out_free);
        sqrt_start    = 1'b0;
        sqrt_radicand = radicand_of(q_job.lo_value);
        unique case (state_reg)
            ST_IDLE: begin
                sqrt_start = !q_empty && !head_direct;
            end
            ST_ROOT_LO: begin
                sqrt_start    = sqrt_done;
                sqrt_radicand = radicand_of(job_reg.hi_value);
            end
            default: begin
                sqrt_start = 1'b0;
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        if (head_direct) begin
                            if (out_free) begin
                                m_lower_reg <= q_job.any_seen ? scaled(q_job.lo_value) : '0;
                                m_upper_reg <= q_job.any_seen ? scaled(q_job.hi_value) : '0;
                                m_error_reg <= q_job.length_error;
                            end
                        end else begin
                            job_reg   <= q_job;
                            state_reg <= ST_ROOT_LO;
                        end
                    end
                end
                ST_ROOT_LO: begin
                    if (sqrt_done) begin
                        lo_root_reg <= sqrt_root;
                        state_reg   <= ST_ROOT_HI;
                    end
                end
                ST_ROOT_HI: begin
                    if (sqrt_done) begin
                        hi_root_reg <= sqrt_root;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_lower_reg <= BOUND_BITS'(lo_root_reg);
                        m_upper_reg <= BOUND_BITS'(hi_root_reg);
                        m_error_reg <= job_reg.length_error;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer
    `VMR_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
    `VMR_ASSERT_NOW(a_root_running, in_root, sqrt_busy || sqrt_done, "root unit idle")
    `VMR_ASSERT_NEXT(a_out_load, out_load, m_valid_reg && (state_reg == ST_IDLE), "missed load")

endmodule
`default_nettype wire

// ===== sv/vector_magnitude_range.sv =====
// Top level of the vector magnitude range block: dimension register, front, queue and back.
//
// Components stream in at one beat per cycle unless input is held off, and
// are grouped into vectors of the configured dimension (0 acts as 1, above 16
// acts as 16). A beat with last_component set closes the stream; its result
// beat carries the lower and upper bound in signed fixed point with 8 fraction
// bits and a flag for an unfinished last vector. The front squares each
// component in one stage and accumulates and tracks extremes in the next, so a
// closing beat goes from stage A into the two-entry result queue once a slot
// is free. A scalar result (dimension 1) goes from the queue head straight to
// the output register once that is free. A magnitude result first runs two
// passes of the shared bit-serial square root unit. Input is held off only
// while the queue is full and another closing beat waits. No clearing pass
// runs after reset.
`default_nettype none
module vector_magnitude_range
    import vmr_pkg::*;
(
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [CFG_BITS-1:0]              cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [COMPONENT_BITS-1:0] s_component,
    input  wire logic                             s_last_component,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [BOUND_BITS-1:0]          m_lower_bound,
    output logic signed [BOUND_BITS-1:0]          m_upper_bound,
    output logic                                  m_length_error
);

    logic [DIM_BITS-1:0] dim_reg;
    logic [DIM_BITS-1:0] dim_next;

    logic     q_push;
    vmr_job_t q_push_job;
    logic     q_full;
    logic     q_pop;
    vmr_job_t q_pop_job;
    logic     q_empty;

    assign cfg_ready = 1'b1;

    // Dimension register, stored already clamped to 1..MAX_DIMENSION
    always_comb begin
        if (cfg_data == '0) begin
            dim_next = DIM_BITS'(1);
        end else if (DIM_BITS'(cfg_data) > DIM_BITS'(MAX_DIMENSION)) begin
            dim_next = DIM_BITS'(MAX_DIMENSION);
        end else begin
            dim_next = DIM_BITS'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            dim_reg <= dim_next;
        end
    end

    vmr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dim              (dim_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_component      (s_component),
        .s_last_component (s_last_component),
        .q_push           (q_push),
        .q_job            (q_push_job),
        .q_full           (q_full)
    );

    vmr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    vmr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_job          (q_pop_job),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lower_bound  (m_lower_bound),
        .m_upper_bound  (m_upper_bound),
        .m_length_error (m_length_error)
    );

endmodule
`default_nettype wire

// ===== tb/vector_magnitude_range_test.sv =====
// Self-checking testbench for the vector magnitude range block.
`timescale 1ns / 100ps

import vmr_pkg::*;

// One result beat as the block should present it.
typedef struct packed {
    logic [BOUND_BITS-1:0] lower;
    logic [BOUND_BITS-1:0] upper;
    logic                  length_error;
} bound_result_t;

// How the components of one stream are filled.
typedef enum int {
    FILL_EXTREME,
    FILL_SMALL,
    FILL_WIDE
} fill_style_t;

// Tracks the range of the incoming stream and keeps the bounds still owed.
class bound_scoreboard;
    logic [CFG_BITS-1:0] dim_reg;
    longint              partial_sum;
    int unsigned         count;
    longint              track_lo;
    longint              track_hi;
    bit                  seen;
    bound_result_t       expected_q[$];
    int unsigned         fail_count;

    function new();
        dim_reg    = 1;
        fail_count = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        partial_sum = 0;
        count       = 0;
        track_lo    = 0;
        track_hi    = 0;
        seen        = 0;
    endfunction

    function void set_dimension(logic [CFG_BITS-1:0] value);
        dim_reg = value;
    endfunction

    // Zero acts as one, anything past the maximum is clamped.
    function int unsigned effective_dimension();
        if (dim_reg == 0)
            return 1;
        if (dim_reg > MAX_DIMENSION)
            return MAX_DIMENSION;
        return dim_reg;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void track(longint v);
        if (!seen || v < track_lo)
            track_lo = v;
        if (!seen || v > track_hi)
            track_hi = v;
        seen = 1;
    endfunction

    // Truncated square root, one result bit at a time from the top.
    function longint unsigned trunc_root(longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int i = 26; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    // Tracked value to fixed point; magnitudes go through the root.
    function logic [BOUND_BITS-1:0] to_fixed(longint v, bit magnitude);
        logic [63:0] wide;
        if (magnitude) begin
            if (v < 0)
                return '0;
            wide = trunc_root(longint'(v) << (2 * FRACTION_BITS));
        end else begin
            wide = v << FRACTION_BITS;
        end
        return wide[BOUND_BITS-1:0];
    endfunction

    // Accepted input beat: update the running range, close the stream on last.
    function void note_component(logic signed [COMPONENT_BITS-1:0] comp, logic last);
        int unsigned   eff;
        longint        value;
        longint        mag;
        bound_result_t r;
        eff   = effective_dimension();
        value = comp;
        if (eff == 1) begin
            track(value);
            partial_sum = 0;
            count       = 0;
        end else begin
            mag = (value < 0) ? -value : value;
            partial_sum += mag * mag;
            if (count + 1 >= eff) begin
                track(partial_sum);
                partial_sum = 0;
                count       = 0;
            end else begin
                count++;
            end
        end
        if (!last)
            return;
        r.length_error = (count != 0);
        if (seen) begin
            r.lower = to_fixed(track_lo, eff != 1);
            r.upper = to_fixed(track_hi, eff != 1);
        end else begin
            r.lower = '0;
            r.upper = '0;
        end
        expected_q.push_back(r);
        clear_stream();
    endfunction

    task report_mismatch(string msg);
        fail_count++;
        if (fail_count <= 50)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Accepted result beat against the oldest owed bounds.
    task check_bounds(logic [BOUND_BITS-1:0] lo, logic [BOUND_BITS-1:0] hi, logic err);
        bound_result_t e;
        if (expected_q.size() == 0) begin
            report_mismatch("result beat with no closed stream pending");
            return;
        end
        e = expected_q.pop_front();
        if (lo !== e.lower)
            report_mismatch($sformatf("lower_bound got %h want %h", lo, e.lower));
        if (hi !== e.upper)
            report_mismatch($sformatf("upper_bound got %h want %h", hi, e.upper));
        if (err !== e.length_error)
            report_mismatch($sformatf("length_error got %b want %b", err, e.length_error));
    endtask
endclass

module vector_magnitude_range_test;

    localparam int LATENCY_SLACK = 80;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [CFG_BITS-1:0]              cfg_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [COMPONENT_BITS-1:0] s_component = '0;
    logic                             s_last_component = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [BOUND_BITS-1:0]     m_lower_bound;
    logic signed [BOUND_BITS-1:0]     m_upper_bound;
    logic                             m_length_error;

    bound_scoreboard sb;
    int unsigned     src_idle_pct = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     components_sent = 0;

    vector_magnitude_range dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_component      (s_component),
        .s_last_component (s_last_component),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lower_bound    (m_lower_bound),
        .m_upper_bound    (m_upper_bound),
        .m_length_error   (m_length_error)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watch both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_component(s_component, s_last_component);
            if (m_valid && m_ready)
                sb.check_bounds(m_lower_bound, m_upper_bound, m_length_error);
        end
    end

    function automatic logic signed [COMPONENT_BITS-1:0] pick_component(fill_style_t fill);
        case (fill)
            FILL_EXTREME: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            FILL_SMALL:   return COMPONENT_BITS'($urandom_range(16) - 8);
            default: begin
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(3))
                        0:       return 16'sh7FFF;
                        1:       return 16'sh8000;
                        2:       return '0;
                        default: return '1;
                    endcase
                end
                return COMPONENT_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic send_component(input logic signed [COMPONENT_BITS-1:0] value,
                                  input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_component      <= value;
        s_last_component <= last;
        do @(posedge aclk); while (!s_ready);
        components_sent++;
    endtask

    // Stop sending, let every owed result out, then give the back time to settle.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (LATENCY_SLACK) @(negedge aclk);
    endtask

    task automatic write_dimension(input logic [CFG_BITS-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_dimension(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole vectors; some one short or long, some of random length.
    task automatic send_stream(input int unsigned dim);
        int unsigned len;
        int unsigned pick;
        fill_style_t fill;
        pick = $urandom_range(9);
        len  = $urandom_range(1, (dim >= 8) ? 2 : 4) * dim;
        if (pick == 0)
            len = $urandom_range(1, 2 * dim + 1);
        else if (pick == 1)
            len = (len > 1 && $urandom_range(1)) ? len - 1 : len + 1;
        case ($urandom_range(5))
            0:       fill = FILL_EXTREME;
            1:       fill = FILL_SMALL;
            default: fill = FILL_WIDE;
        endcase
        for (int unsigned i = 0; i < len; i++)
            send_component(pick_component(fill), i == len - 1);
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                             input int unsigned n);
        int unsigned         target;
        logic [CFG_BITS-1:0] dim_val;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        target         = components_sent + n;
        while (components_sent < target) begin
            case ($urandom_range(7))
                0:       dim_val = '0;
                1:       dim_val = 1;
                2:       dim_val = CFG_BITS'(MAX_DIMENSION);
                3:       dim_val = '1;
                4:       dim_val = CFG_BITS'(MAX_DIMENSION + 1);
                5:       dim_val = 2;
                default: dim_val = CFG_BITS'($urandom_range(31));
            endcase
            write_dimension(dim_val);
            repeat ($urandom_range(1, 4)) send_stream(sb.effective_dimension());
            // sometimes leave a vector open across the next dimension change
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(1, 5)) send_component(pick_component(FILL_WIDE), 1'b0);
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_pct   = 9;
        sink_stall_pct = 48;

        // scalar range at the reset dimension
        send_component(16'sh7FFF, 1'b0);
        send_component(16'sh8000, 1'b1);
        // one whole vector, then an unfinished one
        write_dimension(3);
        send_component(16'sh8000, 1'b0);
        send_component(16'sh7FFF, 1'b0);
        send_component(16'sh8000, 1'b0);
        send_component(5, 1'b1);
        // stream ends before any vector completes
        send_component(0, 1'b1);
        // zero dimension acts as scalar
        write_dimension(0);
        send_component(-1, 1'b1);
        // scalar tracked, then vectors after a change mid-stream
        write_dimension(1);
        send_component(100, 1'b0);
        write_dimension(2);
        send_component(-3, 1'b0);
        send_component(4, 1'b1);
        // negative scalar under a root gives zero
        write_dimension(1);
        send_component(-7, 1'b0);
        write_dimension(2);
        send_component(3, 1'b0);
        send_component(4, 1'b1);
        // count already past the new, smaller dimension
        write_dimension(4);
        send_component(1, 1'b0);
        send_component(1, 1'b0);
        send_component(1, 1'b0);
        write_dimension(2);
        send_component(1, 1'b1);

        run_phase(9, 48, 300);
        run_phase(48, 9, 300);
        run_phase(0, 0, 300);

        wait_for_drain();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== vector_magnitude_range.f =====
+incdir+sv
sv/vmr_pkg.sv
sv/vmr_front.sv
sv/vmr_queue.sv
sv/vmr_sqrt.sv
sv/vmr_back.sv
sv/vector_magnitude_range.sv
tb/vector_magnitude_range_test.sv
